[hw/rtl/thermal_fault_monitor_assert.svh]
// assertion macros for the thermal fault monitor checker
// expects clk and arst_n in the scope of use
`ifndef THERMAL_FAULT_MONITOR_ASSERT_SVH
`define THERMAL_FAULT_MONITOR_ASSERT_SVH

// property checked at every edge outside reset
`define TFM_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// consequent checked in the cycle after the antecedent
`define TFM_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) ante |=> cons) else $error(msg);

`endif

[hw/rtl/tfm_pkg.sv]
// shared types, constants and helpers of the thermal fault monitor
// no dependencies
package tfm_pkg;

	localparam int NUM_ZONES = 4;
	localparam int TEMP_W    = 16;
	localparam int CMD_W     = 14;
	localparam int RPM_W     = 16;
	localparam int CNT_W     = 10;
	localparam int CFG_DW    = 16;
	localparam int CFG_AW    = 3;
	localparam int CODE_W    = 3;

	typedef logic signed [TEMP_W-1:0] temp_t;

	// range and plausibility thresholds
	localparam temp_t             TEMP_LO       = -16'sd4000;
	localparam temp_t             TEMP_HI       = 16'sd12000;
	localparam logic [TEMP_W:0]   COOLANT_GAP   = 17'd6000;
	localparam logic [TEMP_W:0]   STUCK_EPS     = 17'd5;
	localparam logic [CMD_W-1:0]  CMD_ACTIVE    = 14'd5000;
	localparam logic [RPM_W-1:0]  PUMP_MIN_RPM  = 16'd1000;
	localparam logic [RPM_W-1:0]  FAN_MIN_RPM   = 16'd500;
	localparam logic [RPM_W-1:0]  PUMP_GOOD_RPM = 16'd3000;
	localparam logic [RPM_W-1:0]  FAN_GOOD_RPM  = 16'd2000;
	localparam logic [CNT_W-1:0]  CNT_MAX       = 10'd1023;

	// register indexes
	localparam logic [CFG_AW-1:0] REG_PERIOD    = 3'd0;
	localparam logic [CFG_AW-1:0] REG_OVER_TEMP = 3'd1;
	localparam logic [CFG_AW-1:0] REG_SPREAD    = 3'd2;
	localparam logic [CFG_AW-1:0] REG_STUCK     = 3'd3;
	localparam logic [CFG_AW-1:0] REG_FEEDBACK  = 3'd4;
	localparam logic [CFG_AW-1:0] REG_COOLING   = 3'd5;

	// register reset values
	localparam logic [15:0]       RST_PERIOD    = 16'd100;
	localparam logic [14:0]       RST_OVER_TEMP = 15'd5500;
	localparam logic [13:0]       RST_SPREAD    = 14'd2000;
	localparam logic [CNT_W-1:0]  RST_STUCK     = 10'd50;
	localparam logic [CNT_W-1:0]  RST_FEEDBACK  = 10'd100;
	localparam logic [CNT_W-1:0]  RST_COOLING   = 10'd300;

	// fault codes
	localparam logic [CODE_W-1:0] FAULT_NONE      = 3'd0;
	localparam logic [CODE_W-1:0] FAULT_RANGE     = 3'd1;
	localparam logic [CODE_W-1:0] FAULT_IMPLAUS   = 3'd2;
	localparam logic [CODE_W-1:0] FAULT_IMBALANCE = 3'd3;
	localparam logic [CODE_W-1:0] FAULT_PUMP      = 3'd4;
	localparam logic [CODE_W-1:0] FAULT_FAN       = 3'd5;
	localparam logic [CODE_W-1:0] FAULT_COOLING   = 3'd6;
	localparam logic [CODE_W-1:0] FAULT_OVERTEMP  = 3'd7;

	typedef struct packed {
		temp_t temp;
		logic  out_of_range;
	} lane_t;

	typedef struct packed {
		logic             range_fault;
		temp_t            max_temp;
		temp_t            min_temp;
		temp_t            coolant;
		logic [CMD_W-1:0] pump_cmd;
		logic [CMD_W-1:0] fan_cmd;
		logic [RPM_W-1:0] pump_rpm;
		logic [RPM_W-1:0] fan_rpm;
	} sample_t;

	typedef struct packed {
		logic [15:0]      period;
		logic [14:0]      over_temp;
		logic [13:0]      spread;
		logic [CNT_W-1:0] stuck_lim;
		logic [CNT_W-1:0] fb_lim;
		logic [CNT_W-1:0] cool_lim;
	} cfg_t;

	// saturating event counter, cleared when the condition is absent
	function automatic logic [CNT_W-1:0] bump(input logic [CNT_W-1:0] cnt, input logic cond);
		if (!cond) begin
			return '0;
		end
		return (cnt == CNT_MAX) ? CNT_MAX : cnt + 1'b1;
	endfunction

endpackage

[hw/rtl/tfm_lane.sv]
// per-zone lane: range check of one zone temperature
// depends on tfm_pkg
module tfm_lane (
	input  tfm_pkg::temp_t temp,
	output tfm_pkg::lane_t res
);
	import tfm_pkg::*;

	always_comb begin
		res.temp         = temp;
		res.out_of_range = (temp < TEMP_LO) || (temp > TEMP_HI);
	end

endmodule

[hw/rtl/tfm_merge.sv]
// merging stage: zone maximum, minimum and combined range fault of all lanes
// depends on tfm_pkg
module tfm_merge (
	input  tfm_pkg::lane_t lanes [tfm_pkg::NUM_ZONES],
	output logic           range_fault,
	output tfm_pkg::temp_t max_temp,
	output tfm_pkg::temp_t min_temp
);
	import tfm_pkg::*;

	always_comb begin
		range_fault = 1'b0;
		max_temp    = lanes[0].temp;
		min_temp    = lanes[0].temp;
		for (int i = 0; i < NUM_ZONES; i++) begin
			range_fault = range_fault | lanes[i].out_of_range;
			if (lanes[i].temp > max_temp) begin
				max_temp = lanes[i].temp;
			end
			if (lanes[i].temp < min_temp) begin
				min_temp = lanes[i].temp;
			end
		end
	end

endmodule

[hw/rtl/tfm_check.sv]
// check stage: prioritized fault checks and the history and counter state
// depends on tfm_pkg
module tfm_check (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     adv,
	input  tfm_pkg::sample_t         smp,
	input  tfm_pkg::cfg_t            cfg,
	output logic [tfm_pkg::CODE_W-1:0] code
);
	import tfm_pkg::*;

	logic             first_q;
	temp_t            prev_max_q;
	logic [CNT_W-1:0] stuck_cnt_q;
	logic [CNT_W-1:0] pump_cnt_q;
	logic [CNT_W-1:0] fan_cnt_q;
	logic [CNT_W-1:0] cool_cnt_q;

	logic signed [TEMP_W:0] gap, delta, spread;
	logic [TEMP_W:0]        abs_gap, abs_delta;
	temp_t                  over_lim;
	logic [CNT_W-1:0]       stuck_nx, pump_nx, fan_nx, cool_nx;
	logic f_gap, f_rate, f_stuck, f_spread, f_pump, f_fan, f_cool, f_over;
	logic stuck_we, pump_we, fan_we, cool_we, pass_plaus, pass_fan, clean;

	always_comb begin
		gap       = {smp.max_temp[TEMP_W-1], smp.max_temp} - {smp.coolant[TEMP_W-1], smp.coolant};
		abs_gap   = gap[TEMP_W] ? -gap : gap;
		delta     = {smp.max_temp[TEMP_W-1], smp.max_temp} - {prev_max_q[TEMP_W-1], prev_max_q};
		abs_delta = delta[TEMP_W] ? -delta : delta;
		spread    = {smp.max_temp[TEMP_W-1], smp.max_temp} - {smp.min_temp[TEMP_W-1], smp.min_temp};
		over_lim  = {cfg.over_temp[14], cfg.over_temp};

		stuck_nx = bump(stuck_cnt_q, abs_delta < STUCK_EPS);
		pump_nx  = bump(pump_cnt_q, (smp.pump_cmd > CMD_ACTIVE) && (smp.pump_rpm < PUMP_MIN_RPM));
		fan_nx   = bump(fan_cnt_q, (smp.fan_cmd > CMD_ACTIVE) && (smp.fan_rpm < FAN_MIN_RPM));
		cool_nx  = bump(cool_cnt_q, (smp.pump_rpm > PUMP_GOOD_RPM) &&
			(smp.fan_rpm > FAN_GOOD_RPM) && (smp.max_temp > prev_max_q));

		f_gap    = abs_gap > COOLANT_GAP;
		f_rate   = !first_q && ({abs_delta, 1'b0} > {2'b00, cfg.period});
		f_stuck  = !first_q && (stuck_nx > cfg.stuck_lim);
		f_spread = spread > {3'b000, cfg.spread};
		f_pump   = pump_nx > cfg.fb_lim;
		f_fan    = fan_nx > cfg.fb_lim;
		f_cool   = !first_q && (cool_nx > cfg.cool_lim);
		f_over   = smp.max_temp > over_lim;

		stuck_we   = !smp.range_fault && !f_gap && !first_q && !f_rate;
		pass_plaus = !smp.range_fault && !f_gap && !f_rate && !f_stuck;
		pump_we    = pass_plaus && !f_spread;
		fan_we     = pump_we && !f_pump;
		pass_fan   = fan_we && !f_fan;
		cool_we    = pass_fan && !first_q;
		clean      = pass_fan && !f_cool && !f_over;

		if (smp.range_fault) begin
			code = FAULT_RANGE;
		end else if (f_gap || f_rate || f_stuck) begin
			code = FAULT_IMPLAUS;
		end else if (f_spread) begin
			code = FAULT_IMBALANCE;
		end else if (f_pump) begin
			code = FAULT_PUMP;
		end else if (f_fan) begin
			code = FAULT_FAN;
		end else if (f_cool) begin
			code = FAULT_COOLING;
		end else if (f_over) begin
			code = FAULT_OVERTEMP;
		end else begin
			code = FAULT_NONE;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			first_q     <= 1'b1;
			prev_max_q  <= '0;
			stuck_cnt_q <= '0;
			pump_cnt_q  <= '0;
			fan_cnt_q   <= '0;
			cool_cnt_q  <= '0;
		end else if (adv) begin
			if (stuck_we) begin
				stuck_cnt_q <= stuck_nx;
			end
			if (pump_we) begin
				pump_cnt_q <= pump_nx;
			end
			if (fan_we) begin
				fan_cnt_q <= fan_nx;
			end
			if (cool_we) begin
				cool_cnt_q <= cool_nx;
			end
			if (clean) begin
				prev_max_q <= smp.max_temp;
				first_q    <= 1'b0;
			end
		end
	end

endmodule

[hw/rtl/thermal_fault_monitor.sv]
// top level of the thermal fault monitor: config registers, lanes, merge and check stages
// depends on tfm_pkg, tfm_lane, tfm_merge, tfm_check
//
// One sample is accepted per cycle unless in_stall is high, and its fault code appears in the
// output register after stage one: the zone lanes and their merge fill stage one, the check
// stage updates the counters and history and loads the output register. The per-sample state
// loop closes inside the check stage, so samples may follow back to back. in_stall rises only
// while both stage one and the output register hold transactions and out_stall is high.
module thermal_fault_monitor (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cfg_wen,
	input  logic [tfm_pkg::CFG_AW-1:0]  cfg_idx,
	input  logic [tfm_pkg::CFG_DW-1:0]  cfg_wdata,
	input  logic                        in_valid,
	output logic                        in_stall,
	input  logic signed [15:0]          zone_temp_0,
	input  logic signed [15:0]          zone_temp_1,
	input  logic signed [15:0]          zone_temp_2,
	input  logic signed [15:0]          zone_temp_3,
	input  logic signed [15:0]          coolant_temp,
	input  logic [13:0]                 pump_command,
	input  logic [13:0]                 fan_command,
	input  logic [15:0]                 pump_rpm,
	input  logic [15:0]                 fan_rpm,
	output logic                        out_valid,
	input  logic                        out_stall,
	output logic [2:0]                  fault_code
);
	import tfm_pkg::*;

	cfg_t             cfg_q;
	temp_t            zones [NUM_ZONES];
	lane_t            lanes [NUM_ZONES];
	sample_t          smp_c, smp_s1;
	logic             valid_s1, out_valid_q, out_free, adv;
	logic [CODE_W-1:0] code_c, fault_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.period    <= RST_PERIOD;
			cfg_q.over_temp <= RST_OVER_TEMP;
			cfg_q.spread    <= RST_SPREAD;
			cfg_q.stuck_lim <= RST_STUCK;
			cfg_q.fb_lim    <= RST_FEEDBACK;
			cfg_q.cool_lim  <= RST_COOLING;
		end else if (cfg_wen) begin
			case (cfg_idx)
				REG_PERIOD:    cfg_q.period    <= cfg_wdata[15:0];
				REG_OVER_TEMP: cfg_q.over_temp <= cfg_wdata[14:0];
				REG_SPREAD:    cfg_q.spread    <= cfg_wdata[13:0];
				REG_STUCK:     cfg_q.stuck_lim <= cfg_wdata[CNT_W-1:0];
				REG_FEEDBACK:  cfg_q.fb_lim    <= cfg_wdata[CNT_W-1:0];
				REG_COOLING:   cfg_q.cool_lim  <= cfg_wdata[CNT_W-1:0];
				default: ;
			endcase
		end
	end

	assign zones[0] = zone_temp_0;
	assign zones[1] = zone_temp_1;
	assign zones[2] = zone_temp_2;
	assign zones[3] = zone_temp_3;

	for (genvar g = 0; g < NUM_ZONES; g++) begin : g_lane
		tfm_lane u_lane (
			.temp (zones[g]),
			.res  (lanes[g])
		);
	end

	tfm_merge u_merge (
		.lanes       (lanes),
		.range_fault (smp_c.range_fault),
		.max_temp    (smp_c.max_temp),
		.min_temp    (smp_c.min_temp)
	);

	assign smp_c.coolant  = coolant_temp;
	assign smp_c.pump_cmd = pump_command;
	assign smp_c.fan_cmd  = fan_command;
	assign smp_c.pump_rpm = pump_rpm;
	assign smp_c.fan_rpm  = fan_rpm;

	assign out_free = !out_valid_q || !out_stall;
	assign adv      = valid_s1 && out_free;
	assign in_stall = valid_s1 && !out_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			smp_s1 <= smp_c;
		end
	end

	tfm_check u_check (
		.clk    (clk),
		.arst_n (arst_n),
		.adv    (adv),
		.smp    (smp_s1),
		.cfg    (cfg_q),
		.code   (code_c)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_free) begin
			out_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			fault_q <= code_c;
		end
	end

	assign out_valid  = out_valid_q;
	assign fault_code = fault_q;

endmodule

[hw/rtl/tfm_checker.sv]
// port-level checker of the thermal fault monitor and its bind
// depends on thermal_fault_monitor_assert.svh and thermal_fault_monitor
`include "thermal_fault_monitor_assert.svh"

module tfm_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_stall,
	input logic        out_valid,
	input logic        out_stall,
	input logic [2:0]  fault_code
);

	`TFM_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid, "result dropped while stalled")
	`TFM_ASSERT_NEXT(a_code_hold, out_valid && out_stall, $stable(fault_code), "result changed while stalled")
	`TFM_ASSERT(a_stall_cause, in_stall |-> out_valid && out_stall, "input stalled with output free")
	`TFM_ASSERT(a_latency, (in_valid && !in_stall) ##1 !out_stall |=> out_valid, "accepted sample lost")

endmodule

bind thermal_fault_monitor tfm_checker u_tfm_checker (.*);

[sim/thermal_fault_monitor_tb.sv]
// testbench for thermal_fault_monitor: random and directed samples with a fault code predictor
// depends on tfm_pkg and the thermal_fault_monitor rtl
module thermal_fault_monitor_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import tfm_pkg::*;

	typedef struct packed {
		logic [NUM_ZONES-1:0][15:0] zone;
		logic [15:0]                coolant;
		logic [13:0]                pump_cmd;
		logic [13:0]                fan_cmd;
		logic [15:0]                pump_rpm;
		logic [15:0]                fan_rpm;
	} reading_t;

	typedef enum {LIMITS_TYPICAL, LIMITS_WITH_SPARE} limits_kind_t;

	class fault_tracker;
		int period_ms;
		int over_limit;
		int spread_lim;
		int stuck_lim;
		int fb_lim;
		int cool_lim;
		bit first;
		int peak;
		int stuck_cnt;
		int pump_cnt;
		int fan_cnt;
		int cool_cnt;
		logic [CODE_W-1:0] expected_codes [$];
		int errors;

		function new();
			set_reg(REG_PERIOD, RST_PERIOD);
			set_reg(REG_OVER_TEMP, {1'b0, RST_OVER_TEMP});
			set_reg(REG_SPREAD, {2'b00, RST_SPREAD});
			set_reg(REG_STUCK, {6'd0, RST_STUCK});
			set_reg(REG_FEEDBACK, {6'd0, RST_FEEDBACK});
			set_reg(REG_COOLING, {6'd0, RST_COOLING});
			first = 1'b1;
			peak = 0;
			stuck_cnt = 0;
			pump_cnt = 0;
			fan_cnt = 0;
			cool_cnt = 0;
			errors = 0;
		endfunction

		function void set_reg(logic [CFG_AW-1:0] idx, logic [CFG_DW-1:0] data);
			case (idx)
				REG_PERIOD:    period_ms = int'(data);
				REG_OVER_TEMP: over_limit = int'($signed(data[14:0]));
				REG_SPREAD:    spread_lim = int'(data[13:0]);
				REG_STUCK:     stuck_lim = int'(data[9:0]);
				REG_FEEDBACK:  fb_lim = int'(data[9:0]);
				REG_COOLING:   cool_lim = int'(data[9:0]);
				default: ;
			endcase
		endfunction

		function int magnitude(int v);
			return (v < 0) ? -v : v;
		endfunction

		function int count_up(int cnt, bit hit);
			if (!hit) begin
				return 0;
			end
			return (cnt < int'(CNT_MAX)) ? cnt + 1 : int'(CNT_MAX);
		endfunction

		function void note_sample(reading_t r);
			int mx, mn, t, coolant, d, pcmd, fcmd, prpm, frpm, k;
			logic [CODE_W-1:0] code;
			mx = int'($signed(r.zone[0]));
			mn = mx;
			for (k = 1; k < NUM_ZONES; k++) begin
				t = int'($signed(r.zone[k]));
				if (t > mx) mx = t;
				if (t < mn) mn = t;
			end
			coolant = int'($signed(r.coolant));
			pcmd = int'(r.pump_cmd);
			fcmd = int'(r.fan_cmd);
			prpm = int'(r.pump_rpm);
			frpm = int'(r.fan_rpm);
			d = mx - peak;
			code = FAULT_NONE;

			if (mn < int'(TEMP_LO) || mx > int'(TEMP_HI)) begin
				code = FAULT_RANGE;
			end else if (magnitude(mx - coolant) > int'(COOLANT_GAP)) begin
				code = FAULT_IMPLAUS;
			end else if (!first && 2 * magnitude(d) > period_ms) begin
				code = FAULT_IMPLAUS;
			end
			if (code == FAULT_NONE && !first) begin
				stuck_cnt = count_up(stuck_cnt, magnitude(d) < int'(STUCK_EPS));
				if (stuck_cnt > stuck_lim) code = FAULT_IMPLAUS;
			end
			if (code == FAULT_NONE && mx - mn > spread_lim) begin
				code = FAULT_IMBALANCE;
			end
			if (code == FAULT_NONE) begin
				pump_cnt = count_up(pump_cnt,
					pcmd > int'(CMD_ACTIVE) && prpm < int'(PUMP_MIN_RPM));
				if (pump_cnt > fb_lim) code = FAULT_PUMP;
			end
			if (code == FAULT_NONE) begin
				fan_cnt = count_up(fan_cnt, fcmd > int'(CMD_ACTIVE) && frpm < int'(FAN_MIN_RPM));
				if (fan_cnt > fb_lim) code = FAULT_FAN;
			end
			if (code == FAULT_NONE && !first) begin
				cool_cnt = count_up(cool_cnt, prpm > int'(PUMP_GOOD_RPM)
					&& frpm > int'(FAN_GOOD_RPM) && mx > peak);
				if (cool_cnt > cool_lim) code = FAULT_COOLING;
			end
			if (code == FAULT_NONE && mx > over_limit) begin
				code = FAULT_OVERTEMP;
			end
			if (code == FAULT_NONE) begin
				peak = mx;
				first = 1'b0;
			end
			expected_codes.push_back(code);
		endfunction

		function void check_code(logic [CODE_W-1:0] actual, longint unsigned stamp);
			logic [CODE_W-1:0] want;
			if (expected_codes.size() == 0) begin
				$display("%0d ns: fault_code expected none actual %0d", stamp, actual);
				errors++;
			end else begin
				want = expected_codes.pop_front();
				if (actual !== want) begin
					$display("%0d ns: fault_code expected %0d actual %0d", stamp, want, actual);
					errors++;
				end
			end
		endfunction
	endclass

	localparam logic [CFG_AW-1:0] REG_SPARE_A = 3'd6;
	localparam logic [CFG_AW-1:0] REG_SPARE_B = 3'd7;
	localparam int                QUIET_LIMIT = 2000;
	localparam int                DRAIN_CYCLES = 4;

	logic                     clk = 1'b0;
	logic                     arst_n = 1'b0;
	logic                     cfg_wen = 1'b0;
	logic [CFG_AW-1:0]        cfg_idx = '0;
	logic [CFG_DW-1:0]        cfg_wdata = '0;
	logic                     in_valid = 1'b0;
	logic                     in_stall;
	logic signed [15:0]       zone_temp_0 = '0;
	logic signed [15:0]       zone_temp_1 = '0;
	logic signed [15:0]       zone_temp_2 = '0;
	logic signed [15:0]       zone_temp_3 = '0;
	logic signed [15:0]       coolant_temp = '0;
	logic [13:0]              pump_command = '0;
	logic [13:0]              fan_command = '0;
	logic [15:0]              pump_rpm = '0;
	logic [15:0]              fan_rpm = '0;
	logic                     out_valid;
	logic                     out_stall = 1'b0;
	logic [2:0]               fault_code;

	bit                       calm = 1'b0;
	int                       quiet_cycles = 0;
	fault_tracker             board = new();

	thermal_fault_monitor DUT (.*);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) board.check_code(fault_code, $time);
		out_stall <= !calm && ($urandom_range(99) < 38);
	end

	// watchdog on cycles with no transaction on either side
	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= QUIET_LIMIT) begin
			$display("status: fail");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	task automatic push_reading(input reading_t r);
		int gap;
		in_valid <= 1'b1;
		zone_temp_0 <= r.zone[0];
		zone_temp_1 <= r.zone[1];
		zone_temp_2 <= r.zone[2];
		zone_temp_3 <= r.zone[3];
		coolant_temp <= r.coolant;
		pump_command <= r.pump_cmd;
		fan_command <= r.fan_cmd;
		pump_rpm <= r.pump_rpm;
		fan_rpm <= r.fan_rpm;
		do @(posedge clk); while (in_stall);
		board.note_sample(r);
		gap = 0;
		while (!calm && $urandom_range(99) < 38) gap++;
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	task automatic settle();
		in_valid <= 1'b0;
		while (board.expected_codes.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_AW-1:0] idx, input logic [CFG_DW-1:0] data);
		cfg_wen <= 1'b1;
		cfg_idx <= idx;
		cfg_wdata <= data;
		@(posedge clk);
		board.set_reg(idx, data);
	endtask

	task automatic configure(input logic [15:0] period, over, spread, stuck, fb, cool,
			input bit spare);
		settle();
		write_reg(REG_PERIOD, period);
		write_reg(REG_OVER_TEMP, over);
		write_reg(REG_SPREAD, spread);
		write_reg(REG_STUCK, stuck);
		write_reg(REG_FEEDBACK, fb);
		write_reg(REG_COOLING, cool);
		if (spare) begin
			write_reg(REG_SPARE_A, 16'($urandom));
			write_reg(REG_SPARE_B, 16'($urandom));
		end
		cfg_wen <= 1'b0;
	endtask

	task automatic configure_random(input limits_kind_t kind);
		configure(16'($urandom_range(400, 20)), 16'(int'($urandom_range(16000)) - 4000),
			16'($urandom_range(4000, 300)), 16'($urandom_range(12)),
			16'($urandom_range(12)), 16'($urandom_range(12)), kind == LIMITS_WITH_SPARE);
	endtask

	function automatic reading_t even_reading(int lvl, int coolant, int pcmd = 0,
			int prpm = 0, int fcmd = 0, int frpm = 0);
		reading_t r;
		for (int k = 0; k < NUM_ZONES; k++) r.zone[k] = 16'(lvl);
		r.coolant = 16'(coolant);
		r.pump_cmd = 14'(pcmd);
		r.pump_rpm = 16'(prpm);
		r.fan_cmd = 14'(fcmd);
		r.fan_rpm = 16'(frpm);
		return r;
	endfunction

	function automatic logic [13:0] command_value();
		case ($urandom_range(4))
			0: return 14'($urandom_range(5000));
			1: return 14'($urandom_range(10000, 5001));
			2: return 14'($urandom);
			3: return 14'($urandom_range(5001, 4999));
			default: return 14'($urandom_range(10000));
		endcase
	endfunction

	function automatic logic [15:0] speed_value();
		case ($urandom_range(6))
			0: return 16'($urandom_range(999));
			1: return 16'($urandom_range(3000, 1000));
			2: return 16'($urandom_range(65535, 3001));
			3: return 16'($urandom_range(505, 495));
			4: return 16'($urandom_range(2005, 1995));
			5: return 16'($urandom_range(3005, 2995));
			default: return 16'($urandom);
		endcase
	endfunction

	// mostly a drifting pack temperature around the last good maximum, some raw noise
	function automatic reading_t random_reading();
		reading_t r;
		int lvl, stretch, low, hot, pick, swing;
		pick = $urandom_range(99);
		if (pick < 10) begin
			r.zone = {$urandom, $urandom};
			r.coolant = 16'($urandom);
			r.pump_cmd = 14'($urandom);
			r.fan_cmd = 14'($urandom);
			r.pump_rpm = 16'($urandom);
			r.fan_rpm = 16'($urandom);
			return r;
		end
		case ($urandom_range(3))
			0: lvl = board.peak + int'($urandom_range(8)) - 4;
			1, 2: begin
				swing = int'($urandom_range(board.period_ms / 2 + 3));
				lvl = board.peak + ($urandom_range(1) ? swing : -swing);
			end
			default: lvl = int'($urandom_range(16000)) - 4000;
		endcase
		if (pick < 14) begin
			lvl = pick[0] ? 12001 + int'($urandom_range(300)) : -4001 - int'($urandom_range(300));
		end else if (lvl > 12000) begin
			lvl = 12000;
		end else if (lvl < -4000) begin
			lvl = -4000;
		end
		stretch = $urandom_range(1) ? int'($urandom_range(board.spread_lim + 2))
			: int'($urandom_range(400));
		low = lvl - stretch;
		if (low < -4000 && pick >= 14) low = -4000;
		if (low > lvl) low = lvl;
		hot = $urandom_range(NUM_ZONES - 1);
		for (int k = 0; k < NUM_ZONES; k++) begin
			r.zone[k] = 16'(lvl - int'($urandom_range(lvl - low)));
		end
		r.zone[hot] = 16'(lvl);
		r.zone[(hot + 1) % NUM_ZONES] = 16'(low);
		if (pick < 20) begin
			r.coolant = 16'(lvl + int'($urandom_range(14000)) - 7000);
		end else begin
			r.coolant = 16'(lvl + int'($urandom_range(6000)) - 3000);
		end
		r.pump_cmd = command_value();
		r.fan_cmd = command_value();
		r.pump_rpm = speed_value();
		r.fan_rpm = speed_value();
		return r;
	endfunction

	task automatic random_run(input int count);
		for (int n = 0; n < count; n++) push_reading(random_reading());
	endtask

	// long runs that keep the event counters climbing
	task automatic saturate(input bit cooling_run, input int count);
		reading_t r;
		int lvl, hot;
		lvl = cooling_run ? -3500 : 1500;
		for (int n = 0; n < count; n++) begin
			if (cooling_run) lvl += int'($urandom_range(4, 1));
			for (int k = 0; k < NUM_ZONES; k++) begin
				r.zone[k] = 16'(lvl - int'($urandom_range(lvl + 4000)));
			end
			hot = $urandom_range(NUM_ZONES - 1);
			r.zone[hot] = 16'(lvl);
			r.coolant = 16'(lvl + int'($urandom_range(8000)) - 4000);
			if (cooling_run) begin
				r.pump_cmd = command_value();
				r.fan_cmd = command_value();
				r.pump_rpm = 16'($urandom_range(65535, 3001));
				r.fan_rpm = 16'($urandom_range(65535, 2001));
			end else begin
				r.pump_cmd = 14'($urandom_range(16383, 5001));
				r.fan_cmd = 14'($urandom_range(16383, 5001));
				r.pump_rpm = 16'($urandom_range(999));
				r.fan_rpm = 16'($urandom_range(499));
			end
			push_reading(r);
		end
	endtask

	initial begin
		reading_t r;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset limits: range, coolant gap, first sample, rate and spread edges
		r = even_reading(1000, 1000);
		r.zone[2] = 16'(-4001);
		push_reading(r);
		r = even_reading(1000, 1000);
		r.zone[0] = 16'(12001);
		push_reading(r);
		r = even_reading(0, -32768);
		r.zone[0] = 16'(-32768);
		r.zone[3] = 16'(32767);
		push_reading(r);
		push_reading(even_reading(1000, -5001));
		push_reading(even_reading(1000, 7000));
		push_reading(even_reading(1051, 1051));
		push_reading(even_reading(1050, 1050));
		r = even_reading(1050, 1050);
		r.zone[1] = 16'(-951);
		push_reading(r);
		r = even_reading(1050, 1050, 5001, 999, 5000, 0);
		r.zone[1] = 16'(-950);
		push_reading(r);
		push_reading(even_reading(1000, 1000, 10000, 1000));

		// tight counter limits: stuck, pump, fan, cooling, over-temperature
		configure(16'd65535, 16'd3000, 16'd2000, 16'd1, 16'd1, 16'd1, 1'b1);
		push_reading(even_reading(2000, 2000));
		push_reading(even_reading(2000, 2000));
		push_reading(even_reading(2000, 2000));
		push_reading(even_reading(2100, 2100, 10000, 0));
		push_reading(even_reading(2200, 2200, 10000, 0));
		push_reading(even_reading(2300, 2300, 0, 0, 16383, 0));
		push_reading(even_reading(2400, 2400, 0, 0, 10000, 499));
		push_reading(even_reading(2500, 2500, 0, 65535, 0, 65535));
		push_reading(even_reading(2600, 2600, 0, 3001, 0, 2001));
		push_reading(even_reading(3001, 3001));
		push_reading(even_reading(3000, 3000, 0, 3000, 0, 2000));
		push_reading(even_reading(-4000, 2000));
		push_reading(even_reading(12000, 12000));

		configure_random(LIMITS_TYPICAL);
		random_run(100);
		configure(16'd0, 16'(-16384), 16'd0, 16'd0, 16'd0, 16'd0, 1'b0);
		random_run(40);
		configure_random(LIMITS_WITH_SPARE);
		calm = 1'b1;
		random_run(120);
		calm = 1'b0;
		configure(16'd65535, 16'd16383, 16'd16383, 16'd1023, 16'd1023, 16'd1023, 1'b0);
		random_run(50);
		saturate(1'b0, 150);
		saturate(1'b1, 150);
		configure(16'($urandom_range(200, 50)), 16'd12000, 16'd16000, 16'd1022, 16'd1022,
			16'd1022, 1'b0);
		random_run(50);
		configure_random(LIMITS_TYPICAL);
		random_run(70);
		configure(16'd1, 16'(-4000), 16'($urandom_range(16383)), 16'($urandom_range(1023)),
			16'($urandom_range(1023)), 16'($urandom_range(1023)), 1'b1);
		random_run(50);

		settle();
		if (board.errors == 0 && board.expected_codes.size() == 0) begin
			$display("status: pass");
		end else begin
			$display("status: fail");
		end
		$finish;
	end

endmodule
